// ----- rtl/wtok_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// wtok_pkg
// Types, character constants and class checks for the word tokenizer.
// ---------------------------------------------------------------------------
package wtok_pkg;

    // Characters that may sit inside a token between two word bytes
    localparam logic [7:0] ApostropheChar = 8'h27;
    localparam logic [7:0] PeriodChar     = 8'h2E;
    localparam logic [7:0] CommaChar      = 8'h2C;
    localparam logic [7:0] HighByteMin    = 8'h80;

    // Most results one input byte can cause
    localparam int unsigned MaxResults = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
    } out_item_t;

    // Results of one input byte: slot 0 goes out first
    typedef struct packed {
        out_item_t [MaxResults-1:0] item;
        logic [1:0]                 count;
    } res_bundle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_letter(c) || is_numeral(c) || (c >= HighByteMin);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/wtok_tokenizer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// wtok_tokenizer
// Token state registers and the per-byte decision that yields up to three
// results for one input byte.
// ---------------------------------------------------------------------------
module wtok_tokenizer #(
    parameter int unsigned MAX_TOKEN_LEN = 255
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  take,
    input  wire wtok_pkg::in_item_t    in_item,
    output wtok_pkg::res_bundle_t      bundle
);

    localparam logic [7:0] MaxLen = 8'(MAX_TOKEN_LEN);

    logic       in_token_reg,  in_token_next;
    logic [7:0] held_sep_reg,  held_sep_next;
    logic       sep_pend_reg,  sep_pend_next;
    logic [7:0] prev_byte_reg, prev_byte_next;
    logic [7:0] tok_len_reg,   tok_len_next;

    logic [7:0] b;
    logic       last;
    logic       fits;
    logic       handled;
    logic       sep_ok;
    logic [1:0] cnt;
    wtok_pkg::res_bundle_t bundle_c;

    assign b    = in_item.in_byte;
    assign last = in_item.text_last;

    // Held separator stays only between two letters (apostrophe) or digits
    assign fits = (held_sep_reg == wtok_pkg::ApostropheChar)
        ? (wtok_pkg::is_letter(prev_byte_reg) && wtok_pkg::is_letter(b))
        : (wtok_pkg::is_numeral(prev_byte_reg) && wtok_pkg::is_numeral(b));

    assign sep_ok = ((b == wtok_pkg::ApostropheChar) && wtok_pkg::is_letter(prev_byte_reg))
        || (((b == wtok_pkg::PeriodChar) || (b == wtok_pkg::CommaChar))
            && wtok_pkg::is_numeral(prev_byte_reg));

    always_comb begin
        bundle_c       = '0;
        cnt            = 2'd0;
        handled        = 1'b0;
        in_token_next  = in_token_reg;
        held_sep_next  = held_sep_reg;
        sep_pend_next  = sep_pend_reg;
        prev_byte_next = prev_byte_reg;
        tok_len_next   = tok_len_reg;

        if (sep_pend_reg) begin
            sep_pend_next = 1'b0;
            held_sep_next = 8'h00;
            if (fits) begin
                if (tok_len_next < MaxLen) begin
                    bundle_c.item[cnt] = '{out_byte: held_sep_reg, byte_valid: 1'b1,
                                           token_end: 1'b0};
                    cnt          = cnt + 2'd1;
                    tok_len_next = tok_len_next + 8'd1;
                end
                if (tok_len_next < MaxLen) begin
                    bundle_c.item[cnt] = '{out_byte: b, byte_valid: 1'b1, token_end: 1'b0};
                    cnt          = cnt + 2'd1;
                    tok_len_next = tok_len_next + 8'd1;
                end
                prev_byte_next = b;
                handled        = 1'b1;
            end else begin
                bundle_c.item[cnt] = '{out_byte: 8'h00, byte_valid: 1'b0, token_end: 1'b1};
                cnt           = cnt + 2'd1;
                in_token_next = 1'b0;
                tok_len_next  = 8'd0;
            end
        end

        if (!handled) begin
            if (in_token_next) begin
                if (wtok_pkg::is_word(b)) begin
                    if (tok_len_next < MaxLen) begin
                        bundle_c.item[cnt] = '{out_byte: b, byte_valid: 1'b1,
                                               token_end: 1'b0};
                        cnt          = cnt + 2'd1;
                        tok_len_next = tok_len_next + 8'd1;
                    end
                    prev_byte_next = b;
                end else if (!last && sep_ok) begin
                    held_sep_next = b;
                    sep_pend_next = 1'b1;
                end else begin
                    bundle_c.item[cnt] = '{out_byte: 8'h00, byte_valid: 1'b0,
                                           token_end: 1'b1};
                    cnt           = cnt + 2'd1;
                    in_token_next = 1'b0;
                    tok_len_next  = 8'd0;
                    held_sep_next = 8'h00;
                    sep_pend_next = 1'b0;
                end
            end else if (wtok_pkg::is_word(b)) begin
                // first byte of a token always fits, limit is at least one
                bundle_c.item[cnt] = '{out_byte: b, byte_valid: 1'b1, token_end: 1'b0};
                cnt            = cnt + 2'd1;
                in_token_next  = 1'b1;
                tok_len_next   = 8'd1;
                prev_byte_next = b;
            end
        end

        // end of text: close any open token and start clean
        if (last) begin
            if (in_token_next) begin
                bundle_c.item[cnt] = '{out_byte: 8'h00, byte_valid: 1'b0, token_end: 1'b1};
                cnt = cnt + 2'd1;
            end
            in_token_next  = 1'b0;
            held_sep_next  = 8'h00;
            sep_pend_next  = 1'b0;
            prev_byte_next = 8'h00;
            tok_len_next   = 8'd0;
        end

        bundle_c.count = cnt;
    end

    assign bundle = bundle_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_reg  <= 1'b0;
            held_sep_reg  <= 8'h00;
            sep_pend_reg  <= 1'b0;
            prev_byte_reg <= 8'h00;
            tok_len_reg   <= 8'd0;
        end else if (take) begin
            in_token_reg  <= in_token_next;
            held_sep_reg  <= held_sep_next;
            sep_pend_reg  <= sep_pend_next;
            prev_byte_reg <= prev_byte_next;
            tok_len_reg   <= tok_len_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/wtok_result_buf.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// wtok_result_buf
// Result register: holds the results of one byte and hands them out one
// transfer at a time.
// ---------------------------------------------------------------------------
module wtok_result_buf (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire wtok_pkg::res_bundle_t bundle,
    output logic                       room,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output wtok_pkg::out_item_t        m_data
);

    wtok_pkg::res_bundle_t slots_reg;
    logic [1:0] rem_reg;
    logic [1:0] idx_reg;
    logic       pop;

    assign m_valid = (rem_reg != 2'd0);
    assign m_data  = slots_reg.item[idx_reg];
    assign pop     = m_valid && m_ready;
    // next byte may enter as the last held result leaves
    assign room    = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (load) begin
            rem_reg <= bundle.count;
            idx_reg <= 2'd0;
        end else if (pop) begin
            rem_reg <= rem_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slots_reg <= bundle;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/word_tokenizer_stream.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// word_tokenizer_stream
// Streaming word tokenizer with interior apostrophes, periods and commas.
// ---------------------------------------------------------------------------
// Takes one text byte per transfer and sends out token bytes, each token
// followed by one token-end transfer. A byte is classified and the token
// state updated in the cycle it is taken; its results (zero to three) sit
// in a result register and reach the output in the cycle after. The output
// channel carries one result per cycle while m_ready is high, which sets
// the rate: bytes with zero or one result can be taken every cycle while
// m_ready stays high, and a byte with two or three results holds the input.
// A new byte is taken in the same cycle as the last pending result leaves.
// Bytes of a token past MAX_TOKEN_LEN are consumed without output.
module word_tokenizer_stream #(
    parameter int unsigned MAX_TOKEN_LEN = 255
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // text byte input
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire wtok_pkg::in_item_t  s_data,
    // token output
    output logic                     m_valid,
    input  wire logic                m_ready,
    output wtok_pkg::out_item_t      m_data
);

    wtok_pkg::res_bundle_t bundle;
    logic take;

    assign take = s_valid && s_ready;

    // classifier and token state
    wtok_tokenizer #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_tok (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .in_item (s_data),
        .bundle  (bundle)
    );

    // result register, drained one transfer per cycle while m_ready is high
    wtok_result_buf u_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (take),
        .bundle  (bundle),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- rtl/wtok_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// wtok_checker
// Port-level checks for the word tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
module wtok_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire wtok_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire wtok_pkg::out_item_t m_data
);

    // last output transfer was a token end (start of stream counts as one)
    logic last_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_end_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            last_end_reg <= m_data.token_end;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output changed while stalled");

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_valid ^ m_data.token_end))
        else $error("result is neither a byte nor a token end");

    a_no_empty_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_end |-> !last_end_reg)
        else $error("token end without token bytes");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    logic unused_in;
    assign unused_in = s_valid ^ (^s_data);

endmodule

bind word_tokenizer_stream wtok_checker u_wtok_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ----- tb/sv/word_tokenizer_stream_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// word_tokenizer_stream_tb
// Self-checking bench for the streaming word tokenizer.
// ---------------------------------------------------------------------------
// Text bytes go in through the s_ channel, one transfer per byte. Every
// accepted byte runs through a token model in the scoreboard, which queues
// the token bytes and token-end markers it should cause. Every m_ transfer
// is checked field by field against the oldest queued result. Stimulus is
// a handful of directed texts, one over-long token, then random texts built
// mostly from letter and digit runs with interior separators, plus noise.
// ---------------------------------------------------------------------------

class token_scoreboard;
    // model state
    bit          in_token;
    bit          sep_pending;
    logic [7:0]  held_sep;
    logic [7:0]  prev_byte;
    int unsigned tok_len;
    int unsigned max_len;

    wtok_pkg::out_item_t expected_q[$];
    int                  errors;

    function new(int unsigned len_limit);
        max_len = len_limit;
        errors  = 0;
        clear();
    endfunction

    function void clear();
        in_token    = 1'b0;
        sep_pending = 1'b0;
        held_sep    = '0;
        prev_byte   = '0;
        tok_len     = 0;
    endfunction

    function bit is_letter_byte(logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function bit is_num(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function bit is_word_byte(logic [7:0] c);
        return is_letter_byte(c) || is_num(c) || (c >= wtok_pkg::HighByteMin);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void add_expected(wtok_pkg::out_item_t r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    // token byte goes out only while the length limit allows
    function void emit_byte(logic [7:0] c);
        if (tok_len < max_len) begin
            add_expected('{out_byte: c, byte_valid: 1'b1, token_end: 1'b0});
            tok_len++;
        end
    endfunction

    function void close_token();
        add_expected('{out_byte: 8'h00, byte_valid: 1'b0, token_end: 1'b1});
        in_token    = 1'b0;
        tok_len     = 0;
        sep_pending = 1'b0;
        held_sep    = '0;
    endfunction

    // accepted input transfer: queue the results it causes
    function void note_byte(wtok_pkg::in_item_t item);
        logic [7:0] b;
        bit         last;
        bit         fits;
        bit         taken;
        b     = item.in_byte;
        last  = item.text_last;
        taken = 1'b0;
        if (sep_pending) begin
            if (held_sep == wtok_pkg::ApostropheChar)
                fits = is_letter_byte(prev_byte) && is_letter_byte(b);
            else
                fits = is_num(prev_byte) && is_num(b);
            sep_pending = 1'b0;
            if (fits) begin
                emit_byte(held_sep);
                emit_byte(b);
                prev_byte = b;
                taken     = 1'b1;
            end else begin
                close_token();
            end
            held_sep = '0;
        end
        if (!taken) begin
            if (in_token) begin
                if (is_word_byte(b)) begin
                    emit_byte(b);
                    prev_byte = b;
                end else if (!last &&
                             ((b == wtok_pkg::ApostropheChar && is_letter_byte(prev_byte)) ||
                              ((b == wtok_pkg::PeriodChar || b == wtok_pkg::CommaChar) &&
                               is_num(prev_byte)))) begin
                    held_sep    = b;
                    sep_pending = 1'b1;
                end else begin
                    close_token();
                end
            end else if (is_word_byte(b)) begin
                in_token = 1'b1;
                tok_len  = 0;
                emit_byte(b);
                prev_byte = b;
            end
        end
        if (last) begin
            if (in_token)
                close_token();
            clear();
        end
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH %0t: %s", $time, msg);
        errors++;
    endtask

    task check_result(wtok_pkg::out_item_t got);
        wtok_pkg::out_item_t exp;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte=%02h valid=%0b end=%0b",
                                      got.out_byte, got.byte_valid, got.token_end));
        end else begin
            exp = expected_q.pop_front();
            if (got.out_byte !== exp.out_byte)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          got.out_byte, exp.out_byte));
            if (got.byte_valid !== exp.byte_valid)
                report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                          got.byte_valid, exp.byte_valid));
            if (got.token_end !== exp.token_end)
                report_mismatch($sformatf("token_end %0b, expected %0b",
                                          got.token_end, exp.token_end));
        end
    endtask
endclass

module word_tokenizer_stream_tb;

    localparam int unsigned MAX_LEN      = 255;
    localparam int          RANDOM_ITEMS = 230;
    localparam int          HOLD_CYCLES  = 48;    // long receiver hold-off
    localparam int          STALL_LIMIT  = 1000;  // cycles with no transfer at all
    localparam int          SETTLE       = 8;     // quiet cycles after the last result

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    wtok_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    wtok_pkg::out_item_t m_data;

    token_scoreboard sb = new(MAX_LEN);

    int src_idle_pct = 21;
    int snk_idle_pct = 21;
    bit hold_req     = 1'b0;
    int quiet_cycles = 0;

    word_tokenizer_stream #(
        .MAX_TOKEN_LEN(MAX_LEN)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Monitor: note the input transfer first, so a same-edge result still
    // pops in order; then check the output transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Watchdog: too long with no transfer on either side means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("word_tokenizer_stream_tb: FAIL");
            $finish;
        end
    end

    // Receiver: random ready, or a long hold-off on request so the block
    // backs up and stalls its input.
    initial begin
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
                @(negedge aclk);
            end
        end
    end

    // One byte transfer. Entered and left at a falling edge; valid stays
    // high afterwards so back-to-back bytes keep it up.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: b, text_last: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], i == txt.len() - 1);
    endtask

    // Sender pause: drop valid and wait until every queued result is out.
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Byte source for random texts: letter runs, digit runs or noise.
    function automatic logic [7:0] pick_byte(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (r < 80)
                    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h41, 8'h5A))
                                                       : 8'($urandom_range(8'h61, 8'h7A));
                else if (r < 92)
                    return wtok_pkg::ApostropheChar;
                else
                    return 8'($urandom_range(0, 255));
            end
            1: begin
                if (r < 78)
                    return 8'($urandom_range(8'h30, 8'h39));
                else if (r < 92)
                    return ($urandom_range(0, 1) != 0) ? wtok_pkg::PeriodChar
                                                       : wtok_pkg::CommaChar;
                else
                    return 8'($urandom_range(0, 255));
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int         sent;
        int         n;
        int         mode;
        bit         held_off;
        logic [7:0] b;

        sent     = 0;
        held_off = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed texts ---
        send_text("Az'z");      // apostrophe between letters stays in
        send_text("0.9,9");     // period and comma between digits stay in
        send_text("a.b");       // period after a letter ends the token
        send_text("x'9");       // held apostrophe, digit does not fit
        send_text("7,");        // separator on the last byte
        send_byte(8'h00, 1'b0); // extremes and high bytes
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_text("b''");       // held apostrophe followed by another one
        send_text("Z");         // one-byte text
        wait_drain();

        // --- over-long token: digit runs with interior periods ---
        for (int i = 0; i < 258; i++) begin
            if (i % 4 == 3)
                b = wtok_pkg::PeriodChar;
            else
                b = 8'h30 + 8'(i % 10);
            send_byte(b, i == 257);
        end
        wait_drain();

        // --- random texts ---
        while (sent < RANDOM_ITEMS) begin
            // no-idle stretch in the middle of the run
            if (sent >= 120 && sent < 170) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = 21;
                snk_idle_pct = 21;
            end
            if (!held_off && sent >= 80) begin
                hold_req = 1'b1;
                held_off = 1'b1;
            end
            n    = $urandom_range(1, 14);
            mode = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1) : 2;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) == 0)
                    mode = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1) : 2;
                b = pick_byte(mode);
                send_byte(b, i == n - 1);
                sent++;
            end
        end

        wait_drain();
        repeat (SETTLE) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("word_tokenizer_stream_tb: PASS");
        else
            $display("word_tokenizer_stream_tb: FAIL");
        $finish;
    end

endmodule
